/* rtl/mpd_pkg.sv */
package mpd_pkg;

  // field widths
  localparam int YEAR_W       = 12;
  localparam int MONTH_W      = 4;
  localparam int DAY_W        = 5;
  localparam int PHASE_W      = 3;
  localparam int AGE_TENTHS_W = 9;
  localparam int LIT_W        = 10;

  // illumination table size and derived index widths
  localparam int COS_TABLE_ENTRIES = 256;
  localparam int LIT_IDX_W         = $clog2(COS_TABLE_ENTRIES);
  localparam int K_W               = $clog2(COS_TABLE_ENTRIES + 1);

  // calendar
  localparam int MIN_YEAR     = 1900;
  localparam int REF_DAY      = 739201;  // day number of 2024-01-11
  localparam int Q100_W       = 6;
  localparam int DIV100_MUL   = 5243;
  localparam int DIV100_SHIFT = 19;
  localparam int DIVP_W       = YEAR_W + 13;
  localparam int DAY_SUM_W    = 23;
  localparam int DAYS_W       = 21;      // signed day offset from the reference

  // synodic reduction, all q16 days
  localparam int SYNODIC_Q16  = 1935317;
  localparam int REF_TIME_Q16 = 32631;
  localparam int Q_RECIP      = 35508;   // round(2^36 / synodic)
  localparam int Q_SHIFT      = 20;
  localparam int QE_W         = 16;
  localparam int QP_W         = 38;
  localparam int DL_W         = 38;
  localparam int REM_W        = 23;
  localparam int AGE_W        = 21;
  localparam int TENTHS_P_W   = AGE_W + 4;

  // table index estimate: floor((age * n + synodic / 2) / synodic)
  localparam int     K_SHIFT  = 22;
  localparam int     K_HALF   = SYNODIC_Q16 / 2;
  localparam longint K_MUL    = (longint'(COS_TABLE_ENTRIES) << K_SHIFT) / SYNODIC_Q16;
  localparam longint K_HALF_Q = (longint'(K_HALF) << K_SHIFT) / SYNODIC_Q16;
  localparam int     KP_W     = K_SHIFT + K_W;
  localparam int     S_W      = AGE_W + K_W;

  // phase bounds in q16 days
  localparam int PHASE_COUNT = 8;
  localparam int PHASE_BOUND [PHASE_COUNT] = '{
    65536, 483656, 549192, 967311, 1032847, 1450967, 1516503, 1935278
  };

  // q30 constants for the table build
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
  localparam longint          Q30_ONE     = 64'sd1073741824;

  typedef struct packed {
    logic valid;
    logic ok;
  } mpd_ctl_t;

  typedef logic [LIT_W-1:0] lit_table_t [COS_TABLE_ENTRIES];

  // day of the march-based year at which month mp starts
  function automatic logic [8:0] march_day(input logic [MONTH_W-1:0] mp);
    logic [8:0] dd;
    case (mp)
      4'd0:    dd = 9'd0;
      4'd1:    dd = 9'd31;
      4'd2:    dd = 9'd61;
      4'd3:    dd = 9'd92;
      4'd4:    dd = 9'd122;
      4'd5:    dd = 9'd153;
      4'd6:    dd = 9'd184;
      4'd7:    dd = 9'd214;
      4'd8:    dd = 9'd245;
      4'd9:    dd = 9'd275;
      4'd10:   dd = 9'd306;
      4'd11:   dd = 9'd337;
      default: dd = 9'd0;
    endcase
    return dd;
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

  // round(500 * (1 + cos(2 pi k / n))) by quadrant folding and taylor terms in q30
  function automatic logic [LIT_W-1:0] lit_entry(input int k);
    longint unsigned t, q, r, x, x2, tc, ts, scaled;
    longint sc, ss, v;
    t  = longint'(k) * 4;
    q  = t / COS_TABLE_ENTRIES;
    r  = t % COS_TABLE_ENTRIES;
    x  = PI_HALF_Q30 * r / COS_TABLE_ENTRIES;
    x2 = (x * x) >> 30;
    tc = 64'd1073741824;
    ts = x;
    sc = Q30_ONE;
    ss = longint'(x);
    tc = ((tc * x2) >> 30) / 2;   ts = ((ts * x2) >> 30) / 6;
    sc = sc - longint'(tc);       ss = ss - longint'(ts);
    tc = ((tc * x2) >> 30) / 12;  ts = ((ts * x2) >> 30) / 20;
    sc = sc + longint'(tc);       ss = ss + longint'(ts);
    tc = ((tc * x2) >> 30) / 30;  ts = ((ts * x2) >> 30) / 42;
    sc = sc - longint'(tc);       ss = ss - longint'(ts);
    tc = ((tc * x2) >> 30) / 56;  ts = ((ts * x2) >> 30) / 72;
    sc = sc + longint'(tc);       ss = ss + longint'(ts);
    tc = ((tc * x2) >> 30) / 90;  ts = ((ts * x2) >> 30) / 110;
    sc = sc - longint'(tc);       ss = ss - longint'(ts);
    tc = ((tc * x2) >> 30) / 132; ts = ((ts * x2) >> 30) / 156;
    sc = sc + longint'(tc);       ss = ss + longint'(ts);
    tc = ((tc * x2) >> 30) / 182; ts = ((ts * x2) >> 30) / 210;
    sc = sc - longint'(tc);       ss = ss - longint'(ts);
    case (q % 4)
      0:       v = sc;
      1:       v = -ss;
      2:       v = -sc;
      default: v = ss;
    endcase
    v = v + Q30_ONE;
    if (v < 0) begin
      v = 0;
    end
    if (v > 2 * Q30_ONE) begin
      v = 2 * Q30_ONE;
    end
    scaled = (longint'(v) * 500 + (64'd1 << 29)) >> 30;
    return scaled[LIT_W-1:0];
  endfunction

  function automatic lit_table_t lit_table_build();
    lit_table_t tab;
    for (int k = 0; k < COS_TABLE_ENTRIES; k++) begin
      tab[k] = lit_entry(k);
    end
    return tab;
  endfunction

  localparam lit_table_t LIT_TABLE = lit_table_build();

endpackage

/* rtl/mpd_day_count.sv */
module mpd_day_count import mpd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic [YEAR_W-1:0]        year,
  input  logic [MONTH_W-1:0]       month,
  input  logic [DAY_W-1:0]         day,
  output mpd_ctl_t                 ctl,
  output logic signed [DAYS_W-1:0] days
);

  // stage 1: march-based year and the divisions by 100
  logic [YEAR_W-1:0]  yy;
  logic [MONTH_W-1:0] mp;
  logic [DIVP_W-1:0]  y_prod, yy_prod, yq_prod;

  assign yy      = (month <= 4'd2) ? year - 12'd1 : year;
  assign mp      = (month <= 4'd2) ? month + 4'd9 : month - 4'd3;
  assign y_prod  = DIVP_W'(year) * DIVP_W'(DIV100_MUL);
  assign yy_prod = DIVP_W'(yy) * DIVP_W'(DIV100_MUL);
  assign yq_prod = DIVP_W'(yy >> 2) * DIVP_W'(DIV100_MUL);

  logic               s1_valid_r;
  logic [YEAR_W-1:0]  s1_year_r, s1_yy_r;
  logic [MONTH_W-1:0] s1_month_r, s1_mp_r;
  logic [DAY_W-1:0]   s1_day_r;
  logic [Q100_W-1:0]  s1_y_q100_r, s1_yy_q100_r, s1_yy_q400_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_year_r    <= year;
    s1_month_r   <= month;
    s1_day_r     <= day;
    s1_yy_r      <= yy;
    s1_mp_r      <= mp;
    s1_y_q100_r  <= y_prod[DIV100_SHIFT +: Q100_W];
    s1_yy_q100_r <= yy_prod[DIV100_SHIFT +: Q100_W];
    s1_yy_q400_r <= yq_prod[DIV100_SHIFT +: Q100_W];
  end

  // stage 2: date check and day offset
  logic [YEAR_W-1:0]    y_r100;
  logic                 leap;
  logic                 ok_nxt;
  logic [DAY_SUM_W-1:0] dsum;

  assign y_r100 = s1_year_r - YEAR_W'(s1_y_q100_r) * YEAR_W'(100);
  assign leap   = ((s1_year_r[1:0] == 2'd0) && (y_r100 != '0))
               || ((y_r100 == '0) && (s1_y_q100_r[1:0] == 2'd0));
  assign ok_nxt = (s1_year_r >= YEAR_W'(MIN_YEAR)) && (s1_month_r >= 4'd1)
               && (s1_month_r <= 4'd12) && (s1_day_r >= 5'd1)
               && (s1_day_r <= month_days(s1_month_r, leap));
  assign dsum   = DAY_SUM_W'(s1_yy_r) * DAY_SUM_W'(365)
               + DAY_SUM_W'(s1_yy_r >> 2)
               - DAY_SUM_W'(s1_yy_q100_r)
               + DAY_SUM_W'(s1_yy_q400_r)
               + DAY_SUM_W'(march_day(s1_mp_r))
               + DAY_SUM_W'(s1_day_r)
               - DAY_SUM_W'(1)
               - DAY_SUM_W'(REF_DAY);

  mpd_ctl_t                 ctl_r;
  logic signed [DAYS_W-1:0] days_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r.valid <= s1_valid_r;
      ctl_r.ok    <= ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    days_r <= dsum[DAYS_W-1:0];
  end

  assign ctl  = ctl_r;
  assign days = days_r;

endmodule

/* rtl/mpd_age_reduce.sv */
module mpd_age_reduce import mpd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mpd_ctl_t                 ctl_in,
  input  logic signed [DAYS_W-1:0] days,
  output mpd_ctl_t                 ctl,
  output logic [AGE_W-1:0]         age
);

  // stage 3: quotient estimate, within one of the true one
  logic signed [QP_W-1:0] qprod;

  assign qprod = QP_W'(days) * QP_W'(Q_RECIP);

  mpd_ctl_t                 s3_ctl_r;
  logic signed [DAYS_W-1:0] s3_days_r;
  logic signed [QE_W-1:0]   s3_qe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_ctl_r <= '0;
    end else begin
      s3_ctl_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    s3_days_r <= days;
    s3_qe_r   <= qprod[Q_SHIFT +: QE_W];
  end

  // stage 4: remainder, lands in [-month, 2 month)
  logic signed [DL_W-1:0] delta;

  assign delta = (DL_W'(s3_days_r) <<< 16) - DL_W'(REF_TIME_Q16)
               - DL_W'(s3_qe_r) * DL_W'(SYNODIC_Q16);

  mpd_ctl_t                s4_ctl_r;
  logic signed [REM_W-1:0] s4_rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_ctl_r <= '0;
    end else begin
      s4_ctl_r <= s3_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_rem_r <= delta[REM_W-1:0];
  end

  // stage 5: one correction step
  logic signed [REM_W-1:0] fixed;

  always_comb begin
    if (s4_rem_r < 0) begin
      fixed = s4_rem_r + REM_W'(SYNODIC_Q16);
    end else if (s4_rem_r >= REM_W'(SYNODIC_Q16)) begin
      fixed = s4_rem_r - REM_W'(SYNODIC_Q16);
    end else begin
      fixed = s4_rem_r;
    end
  end

  mpd_ctl_t         ctl_r;
  logic [AGE_W-1:0] age_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= s4_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    age_r <= fixed[AGE_W-1:0];
  end

  assign ctl = ctl_r;
  assign age = age_r;

endmodule

/* rtl/mpd_illum.sv */
module mpd_illum import mpd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mpd_ctl_t                ctl_in,
  input  logic [AGE_W-1:0]        age,
  output mpd_ctl_t                ctl,
  output logic [PHASE_W-1:0]      phase,
  output logic [AGE_TENTHS_W-1:0] age_tenths,
  output logic [LIT_W-1:0]        lit_tenths
);

  // stage 6: phase, tenths and the table index estimate
  logic [3:0]            ph_cnt;
  logic [TENTHS_P_W-1:0] tprod;
  logic [KP_W-1:0]       kprod;

  always_comb begin
    ph_cnt = '0;
    for (int i = 0; i < PHASE_COUNT; i++) begin
      if (age >= AGE_W'(PHASE_BOUND[i])) begin
        ph_cnt = ph_cnt + 4'd1;
      end
    end
  end

  assign tprod = TENTHS_P_W'(age) * TENTHS_P_W'(10);
  assign kprod = KP_W'(age) * KP_W'(K_MUL) + KP_W'(K_HALF_Q);

  mpd_ctl_t                s6_ctl_r;
  logic [AGE_W-1:0]        s6_age_r;
  logic [K_W-1:0]          s6_kq_r;
  logic [PHASE_W-1:0]      s6_phase_r;
  logic [AGE_TENTHS_W-1:0] s6_tenths_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_ctl_r <= '0;
    end else begin
      s6_ctl_r <= ctl_in;
    end
  end

  // a count of eight (past the last bound) wraps to new moon
  always_ff @(posedge clk) begin
    s6_age_r    <= age;
    s6_kq_r     <= kprod[K_SHIFT +: K_W];
    s6_phase_r  <= ph_cnt[PHASE_W-1:0];
    s6_tenths_r <= tprod[16 +: AGE_TENTHS_W];
  end

  // stage 7: numerator and estimate times the month
  mpd_ctl_t                s7_ctl_r;
  logic [S_W-1:0]          s7_num_r, s7_prod_r;
  logic [K_W-1:0]          s7_kq_r;
  logic [PHASE_W-1:0]      s7_phase_r;
  logic [AGE_TENTHS_W-1:0] s7_tenths_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_ctl_r <= '0;
    end else begin
      s7_ctl_r <= s6_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    s7_num_r    <= S_W'(s6_age_r) * S_W'(COS_TABLE_ENTRIES) + S_W'(K_HALF);
    s7_prod_r   <= S_W'(s6_kq_r) * S_W'(SYNODIC_Q16);
    s7_kq_r     <= s6_kq_r;
    s7_phase_r  <= s6_phase_r;
    s7_tenths_r <= s6_tenths_r;
  end

  // stage 8: fix the estimate and fold a full turn to zero
  logic [K_W-1:0]       k;
  logic [LIT_IDX_W-1:0] idx_nxt;

  assign k       = (s7_num_r >= s7_prod_r + S_W'(SYNODIC_Q16)) ? s7_kq_r + K_W'(1)
                                                                : s7_kq_r;
  assign idx_nxt = (k == K_W'(COS_TABLE_ENTRIES)) ? '0 : k[LIT_IDX_W-1:0];

  mpd_ctl_t                s8_ctl_r;
  logic [LIT_IDX_W-1:0]    s8_idx_r;
  logic [PHASE_W-1:0]      s8_phase_r;
  logic [AGE_TENTHS_W-1:0] s8_tenths_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s8_ctl_r <= '0;
    end else begin
      s8_ctl_r <= s7_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    s8_idx_r    <= idx_nxt;
    s8_phase_r  <= s7_phase_r;
    s8_tenths_r <= s7_tenths_r;
  end

  // result register, fields cleared for a bad date
  mpd_ctl_t                ctl_r;
  logic [PHASE_W-1:0]      phase_r;
  logic [AGE_TENTHS_W-1:0] tenths_r;
  logic [LIT_W-1:0]        lit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= s8_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    phase_r  <= s8_ctl_r.ok ? s8_phase_r : '0;
    tenths_r <= s8_ctl_r.ok ? s8_tenths_r : '0;
    lit_r    <= s8_ctl_r.ok ? LIT_TABLE[s8_idx_r] : '0;
  end

  assign ctl        = ctl_r;
  assign phase      = phase_r;
  assign age_tenths = tenths_r;
  assign lit_tenths = lit_r;

endmodule

/* rtl/moon_phase_from_date.sv */
// moon phase from a gregorian date. a word (year, month, day) is taken at every
// clock edge where start is high; busy stays low, so a new date can go in every
// cycle. each date gives exactly one result word, shown on the out_ ports for one
// cycle with out_valid high, once the date has gone through the pipeline registers.
// the receiver cannot stall: results must be captured when out_valid is high. the
// throughput of one word per cycle comes from a ten-register pipeline: input
// register, two calendar stages, three stages of synodic reduction, three of phase
// and table index, then the result register. a bad date (year before 1900, month
// outside 1 to 12, day outside the month) gives out_date_ok low and all other
// fields zero. the age is measured from the new moon of 2024-01-11 11:57 utc with
// the date taken at 00:00 utc; dates before it wrap to a positive age.
module moon_phase_from_date import mpd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [YEAR_W-1:0]       in_year,
  input  logic [MONTH_W-1:0]      in_month,
  input  logic [DAY_W-1:0]        in_day,
  output logic                    out_valid,
  output logic                    out_date_ok,
  output logic [PHASE_W-1:0]      out_phase,
  output logic [AGE_TENTHS_W-1:0] out_age_tenths,
  output logic [LIT_W-1:0]        out_lit_tenths
);

  // nothing holds a word back: the pipeline moves every cycle
  assign busy = 1'b0;

  // input register
  logic               in_valid_r;
  logic [YEAR_W-1:0]  in_year_r;
  logic [MONTH_W-1:0] in_month_r;
  logic [DAY_W-1:0]   in_day_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_year_r  <= in_year;
      in_month_r <= in_month;
      in_day_r   <= in_day;
    end
  end

  // calendar check and day offset from the reference
  mpd_ctl_t                 day_ctl;
  logic signed [DAYS_W-1:0] day_offset;

  mpd_day_count u_day_count (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid_r),
    .year     (in_year_r),
    .month    (in_month_r),
    .day      (in_day_r),
    .ctl      (day_ctl),
    .days     (day_offset)
  );

  // q16 moon age, remainder over the mean synodic month
  mpd_ctl_t         age_ctl;
  logic [AGE_W-1:0] age_q16;

  mpd_age_reduce u_age_reduce (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_in (day_ctl),
    .days   (day_offset),
    .ctl    (age_ctl),
    .age    (age_q16)
  );

  // phase code, tenths of a day and illumination lookup
  mpd_ctl_t res_ctl;

  mpd_illum u_illum (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl_in     (age_ctl),
    .age        (age_q16),
    .ctl        (res_ctl),
    .phase      (out_phase),
    .age_tenths (out_age_tenths),
    .lit_tenths (out_lit_tenths)
  );

  assign out_valid   = res_ctl.valid;
  assign out_date_ok = res_ctl.ok;

endmodule
